// File: rtl/ufe_pkg.sv
// ----------------------------------------------------------------------------
// ufe_pkg
// Shared types and constants for the disjoint-set engine: request and
// response payloads, field widths and request type codes.
// ----------------------------------------------------------------------------
package ufe_pkg;

    localparam int TYPE_W  = 1;
    localparam int NODE_W  = 10;
    localparam int COUNT_W = 11;

    // Request type codes
    localparam logic [TYPE_W-1:0] REQ_UNION = 1'b0;
    localparam logic [TYPE_W-1:0] REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_t;

    typedef struct packed {
        logic               already_same;
        logic [COUNT_W-1:0] set_size;
        logic [COUNT_W-1:0] component_count;
    } rsp_t;

endpackage

// File: rtl/ufe_ram.sv
// ----------------------------------------------------------------------------
// ufe_ram
// Simple dual-port RAM: one write port and one read port, registered read
// data, read-first on an address clash.
// ----------------------------------------------------------------------------
module ufe_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 10,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/union_find_engine_unit.sv
// ----------------------------------------------------------------------------
// union_find_engine_unit
// Disjoint-set engine with union by size and full path compression.
// ----------------------------------------------------------------------------
// After reset the engine runs a clearing pass over all NODES entries (1024 by
// default) that sets every parent entry to its own index and every size to
// one; req_ready stays low until it finishes. Each request is then handled
// one at a time by a small sequencer around a simple dual-port parent table
// (one read and one write per cycle); path compression keeps chain depths
// short, and the sequencer returns to its idle state before the next request
// is taken. The main loop is the walk through the parent table, whose read
// data is registered. Node ids of NODES or more are clamped to NODES-1.
// set_size and component_count carry the low 11 bits of the counts.
// The response sits in an output register, so a new request is accepted
// while the previous response still waits; the next response then holds in
// the update step until the register is free.
// ----------------------------------------------------------------------------
module union_find_engine_unit #(
    parameter int NODES = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ufe_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ufe_pkg::rsp_t rsp
);

    import ufe_pkg::*;

    localparam int IDX_W = $clog2(NODES);
    localparam int SZ_W  = $clog2(NODES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_COMP,
        ST_NEXT,
        ST_SZA,
        ST_SZB,
        ST_UPD
    } state_t;

    state_t            state_reg, state_next;
    logic              phase_reg, phase_next;   // 0: walking node_a, 1: node_b
    logic              query_reg, query_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [IDX_W-1:0]  a_reg, a_next;
    logic [IDX_W-1:0]  b_reg, b_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;       // walk pointer, then root
    logic [IDX_W-1:0]  n_reg, n_next;           // compression pointer
    logic [IDX_W-1:0]  la_reg, la_next;
    logic [SZ_W-1:0]   size_a_reg, size_a_next;
    logic [SZ_W-1:0]   sets_reg, sets_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    // Memory ports
    logic              par_we;
    logic [IDX_W-1:0]  par_waddr, par_wdata, par_raddr, par_rdata;
    logic              sz_we;
    logic [IDX_W-1:0]  sz_waddr, sz_raddr;
    logic [SZ_W-1:0]   sz_wdata, sz_rdata;

    // Decode helpers
    logic [IDX_W-1:0]  in_a, in_b, walk_start, big_idx, small_idx;
    logic [SZ_W-1:0]   size_sum;
    logic              same_set, do_join, a_smaller;

    ufe_ram #(.DEPTH(NODES), .WIDTH(IDX_W)) u_parent (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    ufe_ram #(.DEPTH(NODES), .WIDTH(SZ_W)) u_size (
        .clk   (clk),
        .we    (sz_we),
        .waddr (sz_waddr),
        .wdata (sz_wdata),
        .raddr (sz_raddr),
        .rdata (sz_rdata)
    );

    // Clamp incoming node ids to the table
    always_comb
    begin
        if (32'(req.node_a) >= NODES)
            in_a = LAST_IDX;
        else
            in_a = IDX_W'(req.node_a);
        if (32'(req.node_b) >= NODES)
            in_b = LAST_IDX;
        else
            in_b = IDX_W'(req.node_b);
    end

    // Union decision: tie keeps node_a's leader
    assign walk_start = phase_reg ? b_reg : a_reg;
    assign same_set   = (la_reg == cur_reg);
    assign do_join    = (query_reg == REQ_UNION) && !same_set;
    assign a_smaller  = (size_a_reg < sz_rdata);
    assign big_idx    = a_smaller ? cur_reg : la_reg;
    assign small_idx  = a_smaller ? la_reg : cur_reg;
    assign size_sum   = SZ_W'(size_a_reg + sz_rdata);

    assign req_ready  = (state_reg == ST_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Sequencer next state and memory control
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        query_next     = query_reg;
        clr_next       = clr_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        la_next        = la_reg;
        size_a_next    = size_a_reg;
        sets_next      = sets_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        par_we    = 1'b0;
        par_waddr = n_reg;
        par_wdata = cur_reg;
        par_raddr = cur_reg;
        sz_we     = 1'b0;
        sz_waddr  = clr_reg;
        sz_wdata  = SZ_W'(1);
        sz_raddr  = la_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                par_we    = 1'b1;
                par_waddr = clr_reg;
                par_wdata = clr_reg;
                sz_we     = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                par_raddr = in_a;
                if (req_valid)
                begin
                    query_next = req.req_type;
                    a_next     = in_a;
                    b_next     = in_b;
                    cur_next   = in_a;
                    phase_next = 1'b0;
                    state_next = ST_FIND;
                end
            end

            // Follow parents to the root, one read per cycle
            ST_FIND:
            begin
                if (par_rdata == cur_reg)
                begin
                    if (walk_start == cur_reg)
                    begin
                        state_next = phase_reg ? ST_SZA : ST_NEXT;
                    end
                    else
                    begin
                        par_raddr  = walk_start;
                        n_next     = walk_start;
                        state_next = ST_COMP;
                    end
                end
                else
                begin
                    par_raddr = par_rdata;
                    cur_next  = par_rdata;
                end
            end

            // Rewrite every node on the chain to point at the root
            ST_COMP:
            begin
                par_we    = 1'b1;
                par_waddr = n_reg;
                par_wdata = cur_reg;
                if (par_rdata == cur_reg)
                begin
                    state_next = phase_reg ? ST_SZA : ST_NEXT;
                end
                else
                begin
                    par_raddr = par_rdata;
                    n_next    = par_rdata;
                end
            end

            ST_NEXT:
            begin
                la_next    = cur_reg;
                cur_next   = b_reg;
                par_raddr  = b_reg;
                phase_next = 1'b1;
                state_next = ST_FIND;
            end

            ST_SZA:
            begin
                sz_raddr   = la_reg;
                state_next = ST_SZB;
            end

            ST_SZB:
            begin
                sz_raddr    = cur_reg;
                size_a_next = sz_rdata;
                state_next  = ST_UPD;
            end

            // Apply the union for a joining request and post the response
            ST_UPD:
            begin
                sz_raddr = cur_reg;
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.already_same = same_set;
                    if (do_join)
                    begin
                        sz_we     = 1'b1;
                        sz_waddr  = big_idx;
                        sz_wdata  = size_sum;
                        par_we    = 1'b1;
                        par_waddr = small_idx;
                        par_wdata = big_idx;
                        if (sets_reg > SZ_W'(1))
                            sets_next = sets_reg - 1'b1;
                        rsp_next.set_size = COUNT_W'(size_sum);
                    end
                    else
                    begin
                        rsp_next.set_size = COUNT_W'(size_a_reg);
                    end
                    rsp_next.component_count = COUNT_W'(sets_next);
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= 1'b0;
            clr_reg       <= '0;
            sets_reg      <= SZ_W'(NODES);
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_reg       <= clr_next;
            sets_reg      <= sets_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        query_reg  <= query_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        cur_reg    <= cur_next;
        n_reg      <= n_next;
        la_reg     <= la_next;
        size_a_reg <= size_a_next;
    end

`ifndef SYNTHESIS
    // The component count never runs out
    a_sets_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sets_reg != '0)
        else $error("component count reached zero");

    // Compression never rewrites the root itself
    a_comp_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) |-> (n_reg != cur_reg))
        else $error("compression step on the root");

    // A response is only raised by the update step
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_UPD))
        else $error("response raised outside the update step");
`endif

endmodule
